// File: rtl/lkvt_pkg.sv
// Shared types and constants for the linear key/value table.
// Holds request and status codes, the result layout and the controller
// command/status structs. No dependencies.
package lkvt_pkg;

	localparam int unsigned REQ_W     = 3;
	localparam int unsigned IN_USER_W = 5;
	localparam int unsigned OUT_W     = 48;

	localparam logic [REQ_W-1:0] REQ_ADD        = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FIND_VALUE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NULL_KEY = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [6:0]  pad;
		logic [4:0]  entry_count;
		logic        value_out_null;
		logic [31:0] value_out;
		logic        hit;
		logic [1:0]  status;
	} lkvt_result_t;

	typedef struct packed {
		logic capture;
		logic walk;
		logic load_hit;
		logic shift_wr;
		logic commit;
	} lkvt_cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic is_remove;
		logic match;
		logic walk_done;
	} lkvt_sts_t;

endpackage

// File: rtl/lkvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvt_ram #(
	parameter int unsigned WIDTH = 65,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/lkvt_dp.sv
// Datapath of the linear key/value table: request register, fill count,
// scan/shift address walk, entry compare and result register.
// Depends on lkvt_pkg; drives the ports of one lkvt_ram.
module lkvt_dp #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned KEY_WIDTH   = 32,
	parameter int unsigned VALUE_WIDTH = 32,
	localparam int unsigned AW   = $clog2(TABLE_DEPTH),
	localparam int unsigned EW   = KEY_WIDTH + VALUE_WIDTH + 1,
	localparam int unsigned IN_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lkvt_pkg::lkvt_cmd_t            cmd,
	output lkvt_pkg::lkvt_sts_t            sts,
	input  logic [IN_W-1:0]                s_tdata,
	input  logic [lkvt_pkg::IN_USER_W-1:0] s_tuser,
	output logic [lkvt_pkg::OUT_W-1:0]     m_tdata,
	output logic                           ram_wr_en,
	output logic [AW-1:0]                  ram_wr_addr,
	output logic [EW-1:0]                  ram_wr_data,
	output logic                           ram_rd_en,
	output logic [AW-1:0]                  ram_rd_addr,
	input  logic [EW-1:0]                  ram_rd_data
);
	import lkvt_pkg::*;

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [REQ_W-1:0]       req_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic                   knull_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   vnull_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          fill_c;
	logic [CW-1:0]          idx_q;
	logic                   pend_s1;
	logic [AW-1:0]          pidx_s1;
	logic                   hit_q;
	logic [AW-1:0]          hit_idx_q;
	logic [VALUE_WIDTH-1:0] hit_val_q;
	logic                   hit_null_q;
	lkvt_result_t           out_q;
	lkvt_result_t           res_c;

	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic                   rd_null;
	logic                   key_req;
	logic                   match_c;
	logic                   issue;
	logic                   not_full;
	logic                   add_wr;
	logic                   shift_wr;

	assign rd_key  = ram_rd_data[KEY_WIDTH-1:0];
	assign rd_val  = ram_rd_data[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
	assign rd_null = ram_rd_data[EW-1];

	assign key_req = (req_q == REQ_ADD) || (req_q == REQ_LOOKUP) || (req_q == REQ_REMOVE);

	always_comb begin
		if (req_q == REQ_FIND_VALUE) begin
			match_c = vnull_q ? rd_null : (!rd_null && (rd_val == val_q));
		end else begin
			match_c = (rd_key == key_q);
		end
	end

	assign sts.needs_scan = (key_req && !knull_q) || (req_q == REQ_FIND_VALUE);
	assign sts.is_remove  = (req_q == REQ_REMOVE);
	assign sts.match      = pend_s1 && match_c;
	assign sts.walk_done  = !pend_s1 && (idx_q >= fill_q);

	assign issue       = cmd.walk && (idx_q < fill_q);
	assign ram_rd_en   = issue;
	assign ram_rd_addr = idx_q[AW-1:0];

	assign not_full = (fill_q < CW'(TABLE_DEPTH));

	always_comb begin
		res_c  = '0;
		fill_c = fill_q;
		add_wr = 1'b0;
		case (req_q)
			REQ_ADD: begin
				if (knull_q) begin
					res_c.status = ST_NULL_KEY;
				end else if (hit_q) begin
					add_wr = 1'b1;
				end else if (!not_full) begin
					res_c.status = ST_FULL;
				end else begin
					add_wr    = 1'b1;
					fill_c    = fill_q + 1'b1;
					res_c.hit = 1'b1;
				end
			end
			REQ_LOOKUP: begin
				if (knull_q) begin
					res_c.status = ST_NULL_KEY;
				end else if (hit_q) begin
					res_c.hit            = 1'b1;
					res_c.value_out_null = hit_null_q;
					res_c.value_out      = hit_null_q ? 32'd0 : 32'(hit_val_q);
				end else begin
					res_c.value_out_null = 1'b1;
				end
			end
			REQ_FIND_VALUE: begin
				res_c.hit = hit_q;
			end
			REQ_REMOVE: begin
				if (knull_q) begin
					res_c.status = ST_NULL_KEY;
				end else if (hit_q) begin
					res_c.hit = 1'b1;
					fill_c    = fill_q - 1'b1;
				end
			end
			REQ_CLEAR: begin
				fill_c = '0;
			end
			default: begin
				fill_c = fill_q;
			end
		endcase
		res_c.entry_count = 5'(fill_c);
	end

	assign shift_wr = cmd.shift_wr && pend_s1;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = pidx_s1 - 1'b1;
		ram_wr_data = ram_rd_data;
		if (shift_wr) begin
			ram_wr_en = 1'b1;
		end else if (cmd.commit && add_wr) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = hit_q ? hit_idx_q : fill_q[AW-1:0];
			ram_wr_data = {vnull_q, (vnull_q ? '0 : val_q), key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
			end else if (cmd.load_hit) begin
				pend_s1 <= 1'b0;
				hit_q   <= 1'b1;
			end else begin
				pend_s1 <= issue;
			end
			if (cmd.commit) begin
				fill_q <= fill_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= s_tuser[REQ_W-1:0];
			knull_q <= s_tuser[REQ_W];
			vnull_q <= s_tuser[REQ_W+1];
			key_q   <= s_tdata[KEY_WIDTH-1:0];
			val_q   <= s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
			idx_q   <= '0;
		end else if (cmd.load_hit) begin
			hit_idx_q  <= pidx_s1;
			hit_val_q  <= rd_val;
			hit_null_q <= rd_null;
			idx_q      <= CW'(pidx_s1) + 1'b1;
		end else if (issue) begin
			idx_q   <= idx_q + 1'b1;
			pidx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.commit) begin
			out_q <= res_c;
		end
	end

	assign m_tdata = out_q;

endmodule

// File: rtl/lkvt_ctrl.sv
// Controller of the linear key/value table: sequences accept, scan,
// shift-down on remove and result hand-off. Depends on lkvt_pkg.
module lkvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output lkvt_pkg::lkvt_cmd_t cmd,
	input  lkvt_pkg::lkvt_sts_t sts
);
	import lkvt_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		SHIFT,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_c;
	logic   out_free;

	assign s_tready = (state_q == IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmd     = '0;
		state_c = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_c     = SCAN;
				end
			end
			SCAN: begin
				if (!sts.needs_scan) begin
					state_c = FINISH;
				end else if (sts.match) begin
					cmd.load_hit = 1'b1;
					state_c      = sts.is_remove ? SHIFT : FINISH;
				end else if (sts.walk_done) begin
					state_c = FINISH;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (sts.walk_done) begin
					state_c = FINISH;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_c    = IDLE;
				end
			end
			default: begin
				state_c = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_c;
			if (cmd.commit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/linear_key_value_table.sv
// Linear key/value table: insertion-ordered table of unique keys with
// nullable values, searched front to back. One request item in, one result
// item out. Request item on s_*: s_tuser carries req_type and the null flags,
// s_tdata carries key and value_in. Result item on m_*: m_tdata carries
// status, hit, value_out, value_out_null and entry_count.
// Items are handled one at a time. A request is accepted, then the table
// memory is walked with one entry read per cycle (registered read, compare in
// the cycle after the read), stopping at the first match. A remove that hits
// then moves each later entry down one place, one entry per cycle. The result
// is then written to the output register. A null key, a clear or an unused
// code skips the walk.
// The output register holds a result while m_tready is low; a new request can
// be taken and walked meanwhile, and its result waits, with s_tready low,
// until the register frees.
// Reset empties the table and drops m_tvalid; s_tready is high from the first
// cycle after reset. Memory contents are not cleared, only entries below the
// fill count are ever read.
module linear_key_value_table #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned KEY_WIDTH   = 32,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// key, value_in
	input  logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type, key_is_null, value_in_null
	input  logic [lkvt_pkg::IN_USER_W-1:0]                       s_tuser,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// status, hit, value_out, value_out_null, entry_count, zero pad
	output logic [lkvt_pkg::OUT_W-1:0]                           m_tdata
);
	import lkvt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned EW = KEY_WIDTH + VALUE_WIDTH + 1;

	lkvt_cmd_t       cmd;
	lkvt_sts_t       sts;
	logic            ram_wr_en;
	logic [AW-1:0]   ram_wr_addr;
	logic [EW-1:0]   ram_wr_data;
	logic            ram_rd_en;
	logic [AW-1:0]   ram_rd_addr;
	logic [EW-1:0]   ram_rd_data;

	lkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lkvt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tdata     (m_tdata),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	lkvt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// File: rtl/lkvt_checker.sv
// Port-level checks for the linear key/value table, bound to the top level.
// Depends on lkvt_pkg and linear_key_value_table.
module lkvt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lkvt_pkg::OUT_W-1:0]    m_tdata
);
	import lkvt_pkg::*;

	lkvt_result_t res;
	assign res = m_tdata;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result item changed");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.hit) |-> (res.status == ST_OK))
		else $error("hit reported with error status");

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.value_out_null) |-> (res.value_out == 32'd0))
		else $error("null value_out with nonzero value");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
